[rtl/lces_pkg.sv]
// ----------------------------------------------------------------------------
// lces_pkg: shared types and constants for the lidar corridor e-stop
// Field widths, register codes, the unsigned Q0.15 sine table and stage structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lces_pkg;

  localparam int unsigned RAYS_PER_SCAN = 180;

  localparam int unsigned RANGE_W = 12;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned TRIG_W  = 15;
  localparam int unsigned PROD_W  = RANGE_W + TRIG_W;
  localparam int unsigned FRAC_W  = 15;

  localparam logic [RANGE_W-1:0] RANGE_CAP_MM   = 12'd4000;
  localparam logic [RANGE_W-1:0] MIN_RETURN_MM  = 12'd50;
  localparam logic [INDEX_W-1:0] BEARINGS       = 8'd180;
  localparam logic [INDEX_W-1:0] FWD_LAST_BEAR  = 8'd44;
  localparam logic [INDEX_W-1:0] REAR_FIRST_BEAR = 8'd136;
  localparam logic [5:0]         QUARTER_STEP   = 6'd45;
  localparam logic [PROD_W-1:0]  ROUND_HALF     = 27'd16384;

  localparam logic [1:0] REG_STOP_DISTANCE    = 2'd0;
  localparam logic [1:0] REG_RELEASE_DISTANCE = 2'd1;
  localparam logic [1:0] REG_HALF_WIDTH       = 2'd2;

  localparam logic [RANGE_W-1:0] STOP_DISTANCE_RST    = 12'd300;
  localparam logic [RANGE_W-1:0] RELEASE_DISTANCE_RST = 12'd400;
  localparam logic [RANGE_W-1:0] HALF_WIDTH_RST       = 12'd170;

  typedef struct packed {
    logic [RANGE_W-1:0] stop_distance_mm;
    logic [RANGE_W-1:0] release_distance_mm;
    logic [RANGE_W-1:0] corridor_half_width_mm;
  } cfg_t;

  // One ray after the multiply stage
  typedef struct packed {
    logic              use_ray;
    logic              last_ray;
    logic              scan_stale;
    logic [PROD_W-1:0] side_prod;
    logic [PROD_W-1:0] fwd_prod;
  } prod_t;

  // sin(2k deg) in unsigned Q0.15, k = 0..45
  function automatic logic [TRIG_W-1:0] sin_q15(input logic [5:0] k);
    logic [TRIG_W-1:0] v;
    case (k)
      6'd0:  v = 15'd0;     6'd1:  v = 15'd1144;  6'd2:  v = 15'd2286;
      6'd3:  v = 15'd3425;  6'd4:  v = 15'd4560;  6'd5:  v = 15'd5690;
      6'd6:  v = 15'd6813;  6'd7:  v = 15'd7927;  6'd8:  v = 15'd9032;
      6'd9:  v = 15'd10126; 6'd10: v = 15'd11207; 6'd11: v = 15'd12275;
      6'd12: v = 15'd13328; 6'd13: v = 15'd14365; 6'd14: v = 15'd15384;
      6'd15: v = 15'd16384; 6'd16: v = 15'd17364; 6'd17: v = 15'd18324;
      6'd18: v = 15'd19261; 6'd19: v = 15'd20174; 6'd20: v = 15'd21063;
      6'd21: v = 15'd21926; 6'd22: v = 15'd22763; 6'd23: v = 15'd23571;
      6'd24: v = 15'd24351; 6'd25: v = 15'd25102; 6'd26: v = 15'd25822;
      6'd27: v = 15'd26510; 6'd28: v = 15'd27166; 6'd29: v = 15'd27789;
      6'd30: v = 15'd28378; 6'd31: v = 15'd28932; 6'd32: v = 15'd29452;
      6'd33: v = 15'd29935; 6'd34: v = 15'd30382; 6'd35: v = 15'd30792;
      6'd36: v = 15'd31164; 6'd37: v = 15'd31499; 6'd38: v = 15'd31795;
      6'd39: v = 15'd32052; 6'd40: v = 15'd32270; 6'd41: v = 15'd32449;
      6'd42: v = 15'd32588; 6'd43: v = 15'd32688; 6'd44: v = 15'd32748;
      6'd45: v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/lces_ifs.sv]
// ----------------------------------------------------------------------------
// lces_ifs: ray, result and register-write channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lces_ray_if;
  logic                                 valid;
  logic                                 ready;
  logic [lces_pkg::RANGE_W-1:0]         range_mm;
  logic [lces_pkg::INDEX_W-1:0]         ray_index;
  logic                                 last_ray;
  logic                                 scan_stale;
  modport source(output valid, range_mm, ray_index, last_ray, scan_stale, input ready);
  modport sink(input valid, range_mm, ray_index, last_ray, scan_stale, output ready);
endinterface

interface lces_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 stop_active;
  logic [lces_pkg::RANGE_W-1:0]         nearest_forward_mm;
  modport source(output valid, stop_active, nearest_forward_mm, input ready);
  modport sink(input valid, stop_active, nearest_forward_mm, output ready);
endinterface

interface lces_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           index;
  logic [lces_pkg::RANGE_W-1:0]         data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/lces_ray_mult.sv]
// ----------------------------------------------------------------------------
// lces_ray_mult: ray input register, bearing decode and table multiplies
// Registers each item, maps it to a table step and forms range*sin, range*cos.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lces_ray_mult #(
  parameter int unsigned RAYS_PER_SCAN = lces_pkg::RAYS_PER_SCAN
) (
  input  wire logic            clk,
  input  wire logic            rst,
  lces_ray_if.sink             rays,
  output logic                 prod_valid,
  output lces_pkg::prod_t      prod,
  input  wire logic            prod_ready
);

  logic                              a_valid;
  logic [lces_pkg::RANGE_W-1:0]      a_range;
  logic [lces_pkg::INDEX_W-1:0]      a_index;
  logic                              a_last;
  logic                              a_stale;
  logic                              a_ready;

  logic [lces_pkg::INDEX_W-1:0]      bear;
  logic [5:0]                        step;
  logic                              in_window;
  logic                              in_scan;
  logic [lces_pkg::RANGE_W-1:0]      rng;
  logic [lces_pkg::TRIG_W-1:0]       s_val;
  logic [lces_pkg::TRIG_W-1:0]       c_val;
  lces_pkg::prod_t                   prod_next;

  assign a_ready    = !a_valid || prod_ready;
  assign rays.ready = a_ready;

  always_comb begin
    in_scan = 32'(a_index) < RAYS_PER_SCAN;
    bear = (a_index >= lces_pkg::BEARINGS) ? a_index - lces_pkg::BEARINGS : a_index;
    if (bear <= lces_pkg::FWD_LAST_BEAR) begin
      step      = bear[5:0];
      in_window = 1'b1;
    end else if (bear >= lces_pkg::REAR_FIRST_BEAR) begin
      step      = 6'(lces_pkg::BEARINGS - bear);
      in_window = 1'b1;
    end else begin
      step      = 6'd0;
      in_window = 1'b0;
    end
    rng   = (a_range > lces_pkg::RANGE_CAP_MM) ? lces_pkg::RANGE_CAP_MM : a_range;
    s_val = lces_pkg::sin_q15(step);
    c_val = lces_pkg::sin_q15(lces_pkg::QUARTER_STEP - step);
    prod_next.use_ray    = in_scan && in_window && (rng >= lces_pkg::MIN_RETURN_MM);
    prod_next.last_ray   = a_last;
    prod_next.scan_stale = a_stale;
    prod_next.side_prod  = {{lces_pkg::TRIG_W{1'b0}}, rng} *
                           {{lces_pkg::RANGE_W{1'b0}}, s_val};
    prod_next.fwd_prod   = {{lces_pkg::TRIG_W{1'b0}}, rng} *
                           {{lces_pkg::RANGE_W{1'b0}}, c_val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= rays.valid;
      end
      if (prod_ready) begin
        prod_valid <= a_valid;
      end
    end
    if (a_ready && rays.valid) begin
      a_range <= rays.range_mm;
      a_index <= rays.ray_index;
      a_last  <= rays.last_ray;
      a_stale <= rays.scan_stale;
    end
    if (prod_ready && a_valid) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

[rtl/lces_frame_eval.sv]
// ----------------------------------------------------------------------------
// lces_frame_eval: corridor test, running minimum and stop hysteresis
// Folds each ray into the frame minimum and issues the result on the last ray.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lces_frame_eval (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lces_pkg::cfg_t  cfg_regs,
  input  wire logic            prod_valid,
  input  wire lces_pkg::prod_t prod,
  output logic                 prod_ready,
  lces_res_if.source           result
);

  logic [lces_pkg::RANGE_W-1:0] running_min;
  logic                         stop_latched;
  logic                         res_valid;
  logic                         res_stop;
  logic [lces_pkg::RANGE_W-1:0] res_nearest;

  logic [lces_pkg::PROD_W-1:0]  fwd_sum;
  logic [lces_pkg::RANGE_W-1:0] fwd;
  logic                         in_corridor;
  logic                         counted;
  logic [lces_pkg::RANGE_W-1:0] min_next;
  logic [lces_pkg::RANGE_W-1:0] rel;
  logic                         stop_latched_next;
  logic                         res_free;
  logic                         fire;

  assign res_free   = !res_valid || result.ready;
  // only a last ray needs the output slot
  assign prod_ready = !prod_valid || !prod.last_ray || res_free;
  assign fire       = prod_valid && prod_ready;

  always_comb begin
    fwd_sum     = prod.fwd_prod + lces_pkg::ROUND_HALF;
    fwd         = fwd_sum[lces_pkg::PROD_W-1:lces_pkg::FRAC_W];
    in_corridor = prod.side_prod <=
                  {cfg_regs.corridor_half_width_mm, {lces_pkg::FRAC_W{1'b0}}};
    counted     = prod.use_ray && in_corridor;
    min_next    = (counted && fwd < running_min) ? fwd : running_min;
    rel = (cfg_regs.release_distance_mm > cfg_regs.stop_distance_mm) ?
          cfg_regs.release_distance_mm : cfg_regs.stop_distance_mm;
    if (cfg_regs.stop_distance_mm == '0) begin
      stop_latched_next = stop_latched;
    end else if (prod.scan_stale) begin
      stop_latched_next = 1'b1;
    end else if (stop_latched) begin
      stop_latched_next = min_next < rel;
    end else begin
      stop_latched_next = min_next < cfg_regs.stop_distance_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min  <= lces_pkg::RANGE_CAP_MM;
      stop_latched <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (fire) begin
        if (prod.last_ray) begin
          running_min  <= lces_pkg::RANGE_CAP_MM;
          stop_latched <= stop_latched_next;
        end else begin
          running_min <= min_next;
        end
      end
      if (fire && prod.last_ray) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (fire && prod.last_ray) begin
      res_stop    <= (cfg_regs.stop_distance_mm != '0) && stop_latched_next;
      res_nearest <= min_next;
    end
  end

  assign result.valid              = res_valid;
  assign result.stop_active        = res_stop;
  assign result.nearest_forward_mm = res_nearest;

endmodule

`default_nettype wire

[rtl/lidar_corridor_estop_hysteresis_core.sv]
// ----------------------------------------------------------------------------
// lidar_corridor_estop_hysteresis_core: lidar corridor emergency stop
// Nearest forward obstacle in a driving corridor, with latched stop and release.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields                                         Notes
// rays     in   range_mm, ray_index, last_ray, scan_stale      one ray per item
// result   out  stop_active, nearest_forward_mm                one item per last ray
// cfg      in   index (0 stop, 1 release, 2 half width), data  always ready
//
// One ray item is taken per cycle while nothing stalls. A last ray passes the
// input register, the multiply register (range * sin, range * cos) and the
// result register before its result shows.
// The running minimum and the stop latch are the only datapath loops; each
// closes through a single register.
// Reset (rst, synchronous) loads the register defaults, clears the latch and
// reloads the minimum to 4000; no clearing pass is needed.
// A waiting result holds a further last ray in the multiply register, and the
// rays behind it wait too; with the result taken every cycle nothing stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lidar_corridor_estop_hysteresis_core #(
  parameter int unsigned RAYS_PER_SCAN = lces_pkg::RAYS_PER_SCAN
) (
  input  wire logic clk,
  input  wire logic rst,
  lces_ray_if.sink   rays,
  lces_res_if.source result,
  lces_cfg_if.sink   cfg
);

  lces_pkg::cfg_t  cfg_regs;
  logic            prod_valid;
  logic            prod_ready;
  lces_pkg::prod_t prod;

  // Register file: writes must arrive only while idle (the user's duty, not enforced here), so no shadowing.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.stop_distance_mm       <= lces_pkg::STOP_DISTANCE_RST;
      cfg_regs.release_distance_mm    <= lces_pkg::RELEASE_DISTANCE_RST;
      cfg_regs.corridor_half_width_mm <= lces_pkg::HALF_WIDTH_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lces_pkg::REG_STOP_DISTANCE:    cfg_regs.stop_distance_mm       <= cfg.data;
        lces_pkg::REG_RELEASE_DISTANCE: cfg_regs.release_distance_mm    <= cfg.data;
        lces_pkg::REG_HALF_WIDTH:       cfg_regs.corridor_half_width_mm <= cfg.data;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // Front end: decode bearing, look up sin/cos, multiply.
  lces_ray_mult #(
    .RAYS_PER_SCAN (RAYS_PER_SCAN)
  ) u_ray_mult (
    .clk        (clk),
    .rst        (rst),
    .rays       (rays),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_ready (prod_ready)
  );

  // Back end: corridor test, minimum, hysteresis, result register.
  lces_frame_eval u_frame_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_ready (prod_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

[rtl/lces_checker.sv]
// ----------------------------------------------------------------------------
// lces_checker: port-level checks for the lidar corridor e-stop
// Watches the result and cfg channels and a shadow of the stop distance register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lces_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic                         res_stop,
  input wire logic [lces_pkg::RANGE_W-1:0] res_nearest,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [1:0]                   cfg_index,
  input wire logic [lces_pkg::RANGE_W-1:0] cfg_data
);

  logic [lces_pkg::RANGE_W-1:0] stop_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_shadow <= lces_pkg::STOP_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready && cfg_index == lces_pkg::REG_STOP_DISTANCE) begin
      stop_shadow <= cfg_data;
    end
  end

  // A result waiting on the sink holds its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_stop) && $stable(res_nearest))
    else $error("result changed while stalled");

  a_no_res_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_nearest_capped: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_nearest <= lces_pkg::RANGE_CAP_MM)
    else $error("nearest distance beyond cap");

  a_disabled_no_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid && stop_shadow == '0 |-> !res_stop)
    else $error("stop with check disabled");

  // No stop while enabled means the obstacle is at least the stop distance away
  a_clear_is_far: assert property (@(posedge clk) disable iff (rst)
    res_valid && stop_shadow != '0 && !res_stop |-> res_nearest >= stop_shadow)
    else $error("stop released below stop distance");

endmodule

bind lidar_corridor_estop_hysteresis_core lces_checker u_lces_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_stop    (result.stop_active),
  .res_nearest (result.nearest_forward_mm),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready),
  .cfg_index   (cfg.index),
  .cfg_data    (cfg.data)
);

`default_nettype wire
